// File: hdl/glyph_span_rasterizer_macros.svh
// ----------------------------------------------------------------------------
// glyph_span_rasterizer assertion macros
// Shared concurrent assertion wrappers on i_clk.
// ----------------------------------------------------------------------------
`ifndef GLYPH_SPAN_RASTERIZER_MACROS_SVH
`define GLYPH_SPAN_RASTERIZER_MACROS_SVH

// check outside reset
`define GSR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// check that also spans reset
`define GSR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// File: hdl/gsr_pkg.sv
// ----------------------------------------------------------------------------
// gsr_pkg
// Types, constants and the 5x7 glyph table of the span rasterizer.
// ----------------------------------------------------------------------------
package gsr_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int GLYPH_ROWS  = 7;
    localparam int GLYPH_COLS  = 5;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;

    localparam logic [1:0] CFG_ORIGIN_X    = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_Y    = 2'd1;
    localparam logic [1:0] CFG_PIXEL_SCALE = 2'd2;

    typedef struct packed {
        logic [7:0] char_code;
        logic       string_start;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic [6:0]         rect_width;
        logic [3:0]         rect_height;
        logic               last_span;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [3:0]         pixel_scale;
    } t_cfg;

    typedef logic [GLYPH_ROWS-1:0][GLYPH_COLS-1:0] t_rows;

    typedef struct packed {
        t_rows                  rows;
        logic [COORD_WIDTH-1:0] base_x;
        logic [COORD_WIDTH-1:0] base_y;
        logic [3:0]             scale;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    localparam logic [4:0] FONT_ROM [36][7] = '{
        '{5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
        '{5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30},
        '{5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14},
        '{5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30},
        '{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31},
        '{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16},
        '{5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15},
        '{5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
        '{5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
        '{5'd7,  5'd2,  5'd2,  5'd2,  5'd18, 5'd18, 5'd12},
        '{5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17},
        '{5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31},
        '{5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17},
        '{5'd17, 5'd25, 5'd25, 5'd21, 5'd19, 5'd19, 5'd17},
        '{5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
        '{5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16},
        '{5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13},
        '{5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17},
        '{5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30},
        '{5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4},
        '{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
        '{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4},
        '{5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10},
        '{5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17},
        '{5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4},
        '{5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31},
        '{5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14},
        '{5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
        '{5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31},
        '{5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30},
        '{5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2},
        '{5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30},
        '{5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14},
        '{5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8},
        '{5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14},
        '{5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14}
    };

    localparam logic [4:0] QUERY_ROWS [7] = '{5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd0, 5'd4};

    function automatic logic [4:0] row_pattern(input logic [7:0] ch, input logic [2:0] row);
        logic [4:0] bits;
        logic [5:0] idx;
        bits = '0;
        idx  = '0;
        if (ch inside {[8'h41:8'h5A]}) begin
            idx  = 6'(ch - 8'h41);
            bits = FONT_ROM[idx][row];
        end else if (ch inside {[8'h30:8'h39]}) begin
            idx  = 6'(ch - 8'h30) + 6'd26;
            bits = FONT_ROM[idx][row];
        end else if (ch == 8'h2E) begin
            bits = (row == 3'd6) ? 5'd4 : 5'd0;
        end else if (ch == 8'h2D) begin
            bits = (row == 3'd3) ? 5'd14 : 5'd0;
        end else if (ch == 8'h3A) begin
            bits = (row == 3'd2 || row == 3'd5) ? 5'd4 : 5'd0;
        end else if (ch == 8'h27) begin
            bits = (row < 3'd2) ? 5'd4 : 5'd0;
        end else if (ch == 8'h2B) begin
            if (row >= 3'd1 && row <= 3'd5) begin
                bits = (row == 3'd3) ? 5'd31 : 5'd4;
            end
        end else if (ch == 8'h2F) begin
            bits = (row < 3'd5) ? 5'(5'd1 << row) : 5'd0;
        end else if (ch == 8'h3F) begin
            bits = QUERY_ROWS[row];
        end
        return bits;
    endfunction

endpackage

// File: hdl/glyph_span_rasterizer.sv
// ----------------------------------------------------------------------------
// glyph_span_rasterizer
// 5x7 character generator that turns text into filled span rectangles.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall with i_in (char_code, string_start); a
// transaction completes when i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall with o_out, one span rectangle per
// transaction; last_span marks the final span of a character.
// Configuration: i_cfg_we writes i_cfg_data to the register i_cfg_idx
// (origin_x, origin_y, pixel_scale); write only while the block is idle.
// The front takes one character per cycle while the queue is not full and
// updates the cursor at once; newlines, blanks and scale zero produce no
// spans and no back-end work. The back takes a job from the queue, then
// steps through the glyph rows down to the last row with dots, one step per
// row plus one per extra run in a row, at most one span per cycle while the
// output is not stalled; blank leading rows delay the first span. A
// two-entry job queue decouples front and back.
// Reset clears the cursor, the queue and the output valid; origin resets
// to 0 and pixel_scale to 1. A stalled output holds its span, the back
// pauses, and the front keeps accepting until the queue is full.
// ----------------------------------------------------------------------------
`include "glyph_span_rasterizer_macros.svh"

module glyph_span_rasterizer import gsr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    input  t_in_item    i_in,
    output logic        o_stall,
    output logic        o_valid,
    output t_out_item   o_out,
    input  logic        i_stall
);

    t_cfg      r_cfg;
    t_job      push_job, head_job;
    t_q_status q_status;
    logic      push, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x    <= '0;
            r_cfg.origin_y    <= '0;
            r_cfg.pixel_scale <= 4'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ORIGIN_X:    r_cfg.origin_x    <= i_cfg_data;
                CFG_ORIGIN_Y:    r_cfg.origin_y    <= i_cfg_data;
                CFG_PIXEL_SCALE: r_cfg.pixel_scale <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    gsr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_valid),
        .i_in       (i_in),
        .o_stall    (o_stall),
        .i_q_status (q_status),
        .o_push     (push),
        .o_job      (push_job)
    );

    gsr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_head   (head_job),
        .o_status (q_status)
    );

    gsr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_job),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_out      (o_out),
        .i_stall    (i_stall)
    );

    `GSR_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !o_valid,
        "output valid after reset")
    `GSR_ASSERT(a_span_nonzero,
        o_valid |-> (o_out.rect_width != 7'd0 && o_out.rect_height != 4'd0),
        "empty span")
    `GSR_ASSERT(a_span_width,
        o_valid |-> (o_out.rect_width <= 7'({3'b000, o_out.rect_height} * 7'd5)),
        "span wider than glyph")
    `GSR_ASSERT(a_pop_not_empty, pop |-> !q_status.empty, "back pops an empty queue")

endmodule

// File: hdl/gsr_front.sv
// ----------------------------------------------------------------------------
// gsr_front
// Accepts characters, keeps the text cursor and queues glyph jobs.
// ----------------------------------------------------------------------------
module gsr_front import gsr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_valid,
    input  t_in_item  i_in,
    output logic      o_stall,
    input  t_q_status i_q_status,
    output logic      o_push,
    output t_job      o_job
);

    logic [COORD_WIDTH-1:0] r_cx, n_cx;
    logic [COORD_WIDTH-1:0] r_cy, n_cy;
    logic [COORD_WIDTH-1:0] org_x, org_y, base_x, base_y;
    logic [7:0]             ch;
    logic                   accept, newline, any_bits;
    t_rows                  rows;

    assign o_stall = i_q_status.full;
    assign accept  = i_valid && !i_q_status.full;
    assign org_x   = COORD_WIDTH'(i_cfg.origin_x);
    assign org_y   = COORD_WIDTH'(i_cfg.origin_y);
    assign base_x  = i_in.string_start ? org_x : r_cx;
    assign base_y  = i_in.string_start ? org_y : r_cy;
    assign newline = (i_in.char_code == CHAR_NEWLINE);
    assign ch      = (i_in.char_code inside {[8'h61:8'h7A]}) ? i_in.char_code - 8'd32
                                                              : i_in.char_code;

    always_comb begin
        any_bits = 1'b0;
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            rows[r]  = row_pattern(ch, 3'(r));
            any_bits = any_bits | (rows[r] != '0);
        end
    end

    always_comb begin
        n_cx = r_cx;
        n_cy = r_cy;
        if (accept) begin
            if (newline) begin
                n_cx = org_x;
                n_cy = base_y + COORD_WIDTH'(i_cfg.pixel_scale) * COORD_WIDTH'(9);
            end else begin
                n_cx = base_x + COORD_WIDTH'(i_cfg.pixel_scale) * COORD_WIDTH'(6);
                n_cy = base_y;
            end
        end
    end

    assign o_push       = accept && !newline && (i_cfg.pixel_scale != 4'd0) && any_bits;
    assign o_job.rows   = rows;
    assign o_job.base_x = base_x;
    assign o_job.base_y = base_y;
    assign o_job.scale  = i_cfg.pixel_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
        end else begin
            r_cx <= n_cx;
            r_cy <= n_cy;
        end
    end

endmodule

// File: hdl/gsr_queue.sv
// ----------------------------------------------------------------------------
// gsr_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module gsr_queue import gsr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_job      i_job,
    input  logic      i_pop,
    output t_job      o_head,
    output t_q_status o_status
);

    t_job       r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push, do_pop;

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

// File: hdl/gsr_back.sv
// ----------------------------------------------------------------------------
// gsr_back
// Scans the glyph rows of the head job and emits at most one span per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module gsr_back import gsr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_head,
    input  t_q_status i_q_status,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_item o_out,
    input  logic      i_stall
);

    logic             r_loaded, n_loaded;
    logic [2:0]       r_row, n_row;
    logic [4:0]       r_rem, n_rem;
    logic             r_valid;
    t_out_item        r_out;
    logic             out_free, emit, later_bits, seen, stop, last;
    logic [2:0]       start, len;
    logic [4:0]       run_mask, rem_left, next_bits;
    logic [6:0]       off_x, off_y, width;

    assign out_free  = !r_valid || !i_stall;
    assign next_bits = (r_row == 3'd6) ? 5'd0 : i_head.rows[r_row + 3'd1];

    always_comb begin
        start    = '0;
        len      = '0;
        seen     = 1'b0;
        stop     = 1'b0;
        run_mask = '0;
        for (int c = 0; c < GLYPH_COLS; c++) begin
            if (r_rem[GLYPH_COLS-1-c]) begin
                if (!seen) begin
                    seen  = 1'b1;
                    start = 3'(c);
                end
                if (!stop) begin
                    len = len + 3'd1;
                    run_mask[GLYPH_COLS-1-c] = 1'b1;
                end
            end else if (seen) begin
                stop = 1'b1;
            end
        end
    end

    always_comb begin
        later_bits = 1'b0;
        for (int k = 0; k < GLYPH_ROWS; k++) begin
            if (3'(k) > r_row && i_head.rows[k] != '0) begin
                later_bits = 1'b1;
            end
        end
    end

    assign rem_left = r_rem & ~run_mask;
    assign emit     = r_loaded && (r_rem != '0) && out_free;
    assign last     = (rem_left == '0) && !later_bits;
    assign off_x    = 7'(start) * 7'(i_head.scale);
    assign off_y    = 7'(r_row) * 7'(i_head.scale);
    assign width    = 7'(len) * 7'(i_head.scale);
    assign o_pop    = emit && last;

    always_comb begin
        n_loaded = r_loaded;
        n_row    = r_row;
        n_rem    = r_rem;
        if (!r_loaded) begin
            if (!i_q_status.empty) begin
                n_loaded = 1'b1;
                n_row    = 3'd0;
                n_rem    = i_head.rows[0];
            end
        end else if (r_rem == '0) begin
            n_row = r_row + 3'd1;
            n_rem = next_bits;
        end else if (emit) begin
            if (last) begin
                n_loaded = 1'b0;
            end else if (rem_left == '0) begin
                n_row = r_row + 3'd1;
                n_rem = next_bits;
            end else begin
                n_rem = rem_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.rect_x      <= 16'(i_head.base_x + COORD_WIDTH'(off_x));
            r_out.rect_y      <= 16'(i_head.base_y + COORD_WIDTH'(off_y));
            r_out.rect_width  <= width;
            r_out.rect_height <= i_head.scale;
            r_out.last_span   <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= 1'b0;
            r_row    <= 3'd0;
            r_rem    <= 5'd0;
            r_valid  <= 1'b0;
        end else begin
            r_loaded <= n_loaded;
            r_row    <= n_row;
            r_rem    <= n_rem;
            if (out_free) begin
                r_valid <= emit;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

// File: tb/tb_glyph_span_rasterizer.sv
// ----------------------------------------------------------------------------
// tb_glyph_span_rasterizer
// Self-checking bench for the 5x7 glyph span rasterizer. A queue of
// characters feeds a clocked driver. A clocked monitor compares each span
// with the oldest one predicted at input acceptance. The run covers several
// origin and scale settings, wrap at the coordinate edges, scale zero, a
// long output hold-off and random idling on both channels.
// ----------------------------------------------------------------------------
module tb_glyph_span_rasterizer;
    import gsr_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 300;

    localparam logic [4:0] GLYPH_DOTS [36][7] = '{
        '{14, 17, 17, 31, 17, 17, 17}, '{30, 17, 17, 30, 17, 17, 30},
        '{14, 17, 16, 16, 16, 17, 14}, '{30, 17, 17, 17, 17, 17, 30},
        '{31, 16, 16, 30, 16, 16, 31}, '{31, 16, 16, 30, 16, 16, 16},
        '{14, 17, 16, 23, 17, 17, 15}, '{17, 17, 17, 31, 17, 17, 17},
        '{14,  4,  4,  4,  4,  4, 14}, '{ 7,  2,  2,  2, 18, 18, 12},
        '{17, 18, 20, 24, 20, 18, 17}, '{16, 16, 16, 16, 16, 16, 31},
        '{17, 27, 21, 21, 17, 17, 17}, '{17, 25, 25, 21, 19, 19, 17},
        '{14, 17, 17, 17, 17, 17, 14}, '{30, 17, 17, 30, 16, 16, 16},
        '{14, 17, 17, 17, 21, 18, 13}, '{30, 17, 17, 30, 20, 18, 17},
        '{15, 16, 16, 14,  1,  1, 30}, '{31,  4,  4,  4,  4,  4,  4},
        '{17, 17, 17, 17, 17, 17, 14}, '{17, 17, 17, 17, 17, 10,  4},
        '{17, 17, 17, 21, 21, 21, 10}, '{17, 17, 10,  4, 10, 17, 17},
        '{17, 17, 10,  4,  4,  4,  4}, '{31,  1,  2,  4,  8, 16, 31},
        '{14, 17, 19, 21, 25, 17, 14}, '{ 4, 12,  4,  4,  4,  4, 14},
        '{14, 17,  1,  2,  4,  8, 31}, '{30,  1,  1, 14,  1,  1, 30},
        '{ 2,  6, 10, 18, 31,  2,  2}, '{31, 16, 16, 30,  1,  1, 30},
        '{14, 16, 16, 30, 17, 17, 14}, '{31,  1,  2,  4,  8,  8,  8},
        '{14, 17, 17, 14, 17, 17, 14}, '{14, 17, 17, 15,  1,  1, 14}
    };

    localparam logic [4:0] QMARK_DOTS [7] = '{14, 17, 1, 2, 4, 0, 4};
    localparam logic [7:0] PUNCT_CHARS [7] = '{".", "-", ":", "'", "+", "/", "?"};

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_ORIGIN_X;
    logic [15:0] i_cfg_data = 16'd0;
    logic        i_valid = 1'b0;
    t_in_item    i_in = '0;
    logic        o_stall;
    logic        o_valid;
    t_out_item   o_out;
    logic        i_stall = 1'b1;

    logic        idle_enable = 1'b1;
    logic        rx_hold = 1'b0;

    t_in_item    pending_chars[$];
    t_out_item   expected_spans[$];

    logic [15:0] org_x = 16'd0;
    logic [15:0] org_y = 16'd0;
    logic [3:0]  dot_scale = 4'd1;
    logic [15:0] cur_x = 16'd0;
    logic [15:0] cur_y = 16'd0;

    int          send_gap = 0;
    int          stall_left = 0;
    int          error_count = 0;

    glyph_span_rasterizer dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #12000000;
        $display("tb_glyph_span_rasterizer: errors");
        $finish;
    end

    function automatic logic [4:0] glyph_row(input logic [7:0] ch, input int row);
        logic [4:0] bits;
        bits = 5'd0;
        if (ch >= "A" && ch <= "Z") begin
            bits = GLYPH_DOTS[int'(ch - "A")][row];
        end else if (ch >= "0" && ch <= "9") begin
            bits = GLYPH_DOTS[26 + int'(ch - "0")][row];
        end else begin
            case (ch)
                ".": bits = (row == 6) ? 5'd4 : 5'd0;
                "-": bits = (row == 3) ? 5'd14 : 5'd0;
                ":": bits = (row == 2 || row == 5) ? 5'd4 : 5'd0;
                "'": bits = (row < 2) ? 5'd4 : 5'd0;
                "+": bits = (row >= 1 && row <= 5) ? ((row == 3) ? 5'd31 : 5'd4) : 5'd0;
                "/": bits = (row < 5) ? 5'(1 << row) : 5'd0;
                "?": bits = QMARK_DOTS[row];
                default: bits = 5'd0;
            endcase
        end
        return bits;
    endfunction

    task automatic predict_spans(input t_in_item item);
        logic [7:0] ch;
        logic [4:0] bits;
        int         col;
        int         start;
        t_out_item  span;
        t_out_item  spans[$];
        ch = item.char_code;
        if (item.string_start) begin
            cur_x = org_x;
            cur_y = org_y;
        end
        if (ch == CHAR_NEWLINE) begin
            cur_x = org_x;
            cur_y = cur_y + 16'(9 * dot_scale);
            return;
        end
        if (ch >= "a" && ch <= "z") ch = ch - 8'd32;
        if (dot_scale != 4'd0) begin
            for (int row = 0; row < 7; row++) begin
                bits = glyph_row(ch, row);
                col = 0;
                while (col < 5) begin
                    if (!bits[4 - col]) begin
                        col++;
                    end else begin
                        start = col;
                        while (col < 5 && bits[4 - col]) col++;
                        span.rect_x      = cur_x + 16'(start * dot_scale);
                        span.rect_y      = cur_y + 16'(row * dot_scale);
                        span.rect_width  = 7'((col - start) * dot_scale);
                        span.rect_height = dot_scale;
                        span.last_span   = 1'b0;
                        spans.push_back(span);
                    end
                end
            end
            if (spans.size() > 0) spans[spans.size() - 1].last_span = 1'b1;
            foreach (spans[k]) expected_spans.push_back(spans[k]);
        end
        cur_x = cur_x + 16'(6 * dot_scale);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_valid && !o_stall) predict_spans(i_in);
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_chars.size() > 0) begin
                    i_in <= pending_chars.pop_front();
                    i_valid <= 1'b1;
                    if (idle_enable && $urandom_range(0, 5) == 0) begin
                        send_gap = $urandom_range(1, 11);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        logic      hold_now;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_spans.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("unexpected span: x=%0d y=%0d w=%0d h=%0d last=%0b",
                             o_out.rect_x, o_out.rect_y, o_out.rect_width,
                             o_out.rect_height, o_out.last_span);
                end
            end else begin
                want = expected_spans.pop_front();
                if (o_out.rect_x !== want.rect_x || o_out.rect_y !== want.rect_y ||
                    o_out.rect_width !== want.rect_width ||
                    o_out.rect_height !== want.rect_height ||
                    o_out.last_span !== want.last_span) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("span mismatch: expected x=%0d y=%0d w=%0d h=%0d last=%0b",
                                 want.rect_x, want.rect_y, want.rect_width,
                                 want.rect_height, want.last_span);
                        $display("               actual   x=%0d y=%0d w=%0d h=%0d last=%0b",
                                 o_out.rect_x, o_out.rect_y, o_out.rect_width,
                                 o_out.rect_height, o_out.last_span);
                    end
                end
            end
        end
        hold_now = rx_hold;
        if (stall_left > 0) begin
            stall_left--;
            hold_now = 1'b1;
        end else if (idle_enable && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 10);
            hold_now = 1'b1;
        end
        i_stall <= hold_now;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_ORIGIN_X:    org_x = value;
            CFG_ORIGIN_Y:    org_y = value;
            CFG_PIXEL_SCALE: dot_scale = value[3:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_layout(input logic [15:0] ox, input logic [15:0] oy,
                              input logic [3:0] sc);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_PIXEL_SCALE, {12'd0, sc});
    endtask

    task automatic queue_char(input logic [7:0] ch, input logic start);
        t_in_item item;
        item.char_code    = ch;
        item.string_start = start;
        pending_chars.push_back(item);
    endtask

    function automatic logic [7:0] rand_char();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) return 8'("A" + $urandom_range(0, 25));
        if (pick < 45) return 8'("a" + $urandom_range(0, 25));
        if (pick < 60) return 8'("0" + $urandom_range(0, 9));
        if (pick < 72) return PUNCT_CHARS[$urandom_range(0, 6)];
        if (pick < 80) return CHAR_NEWLINE;
        if (pick < 86) return " ";
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_random(input int count);
        @(negedge i_clk);
        queue_char(rand_char(), 1'b1);
        for (int k = 1; k < count; k++) begin
            queue_char(rand_char(), $urandom_range(0, 15) == 0);
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_chars.size() != 0 || i_valid || expected_spans.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        @(negedge i_clk);
        queue_char("A", 1'b1);
        queue_char("Z", 1'b0);
        queue_char("M", 1'b0);
        queue_char("W", 1'b0);
        queue_char("0", 1'b0);
        queue_char("9", 1'b0);
        queue_char("a", 1'b0);
        queue_char("z", 1'b0);
        queue_char(".", 1'b0);
        queue_char("-", 1'b0);
        queue_char(":", 1'b0);
        queue_char("'", 1'b0);
        queue_char("+", 1'b0);
        queue_char("/", 1'b0);
        queue_char("?", 1'b0);
        queue_char(" ", 1'b0);
        queue_char(8'd0, 1'b0);
        queue_char(8'd255, 1'b0);
        queue_char(8'd128, 1'b0);
        queue_char(CHAR_NEWLINE, 1'b0);
        queue_char("%", 1'b0);
        queue_char("8", 1'b0);
        queue_char("Q", 1'b1);
        wait_drained();

        set_layout(16'h7FFF, 16'h7FFF, 4'd15);
        queue_random(40);
        wait_drained();

        set_layout(16'h8000, 16'h8000, 4'd0);
        @(negedge i_clk);
        queue_char("W", 1'b1);
        queue_char(CHAR_NEWLINE, 1'b0);
        queue_char("8", 1'b0);
        queue_random(20);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            set_layout(16'($urandom), 16'($urandom), 4'($urandom_range(1, 15)));
            if (phase == 2) begin
                idle_enable <= 1'b0;
                rx_hold <= 1'b1;
                queue_random(40);
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end else begin
                idle_enable <= ($urandom_range(0, 3) != 0);
                queue_random(40);
            end
            wait_drained();
        end

        idle_enable <= 1'b0;
        set_layout(16'($urandom), 16'($urandom), 4'($urandom_range(1, 15)));
        queue_random(40);
        wait_drained();

        if (error_count == 0) begin
            $display("tb_glyph_span_rasterizer: clean");
        end else begin
            $display("tb_glyph_span_rasterizer: errors");
        end
        $finish;
    end

endmodule
